### sv/srctok_pkg.sv
// Shared constants, keyword tables and character classes for the source text tokenizer.
// No dependencies.
package srctok_pkg;

    localparam int CHAR_W       = 8;
    localparam int KIND_W       = 5;
    localparam int KW_COUNT     = 5;
    localparam int KW_IDX_W     = 3;
    localparam int KW_LEN_W     = 4;
    localparam int TQ_DEPTH     = 4;
    localparam int TQ_PTR_W     = 2;
    localparam int TQ_CNT_W     = 3;
    localparam int POSITION_BITS_DEF = 24;
    localparam int LENGTH_BITS_DEF   = 16;

    localparam logic [KW_LEN_W-1:0] MM_LEN = 4'd10;

    localparam logic [KIND_W-1:0] KIND_METASTRUCT = 5'd0;
    localparam logic [KIND_W-1:0] KIND_METAMETHOD = 5'd1;
    localparam logic [KIND_W-1:0] KIND_STRUCT     = 5'd2;
    localparam logic [KIND_W-1:0] KIND_IDENT      = 5'd3;
    localparam logic [KIND_W-1:0] KIND_NUMBER     = 5'd4;
    localparam logic [KIND_W-1:0] KIND_LPAREN     = 5'd5;
    localparam logic [KIND_W-1:0] KIND_RPAREN     = 5'd6;
    localparam logic [KIND_W-1:0] KIND_LBRACE     = 5'd7;
    localparam logic [KIND_W-1:0] KIND_RBRACE     = 5'd8;
    localparam logic [KIND_W-1:0] KIND_SEMI       = 5'd9;
    localparam logic [KIND_W-1:0] KIND_COLON      = 5'd10;
    localparam logic [KIND_W-1:0] KIND_STAR       = 5'd11;
    localparam logic [KIND_W-1:0] KIND_COMMA      = 5'd12;
    localparam logic [KIND_W-1:0] KIND_LBRACKET   = 5'd13;
    localparam logic [KIND_W-1:0] KIND_RBRACKET   = 5'd14;
    localparam logic [KIND_W-1:0] KIND_CLASS      = 5'd15;
    localparam logic [KIND_W-1:0] KIND_ENUM       = 5'd16;
    localparam logic [KIND_W-1:0] KIND_UNKNOWN    = 5'd17;

    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_UNDER = 8'h5F;
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;

    typedef struct packed {
        logic [1:0] num;
    } push_t;

    function automatic logic [79:0] kw_text(input logic [KW_IDX_W-1:0] k);
        logic [79:0] t;
        t = '0;
        unique case (k)
            3'd0:    t = {"struct", 32'h0};
            3'd1:    t = "MetaStruct";
            3'd2:    t = "MetaMethod";
            3'd3:    t = {"enum", 48'h0};
            3'd4:    t = {"class", 40'h0};
            default: t = '0;
        endcase
        return t;
    endfunction

    function automatic logic [CHAR_W-1:0] kw_char(input logic [KW_IDX_W-1:0] k,
                                                   input logic [KW_LEN_W-1:0] idx);
        logic [79:0] t;
        t = kw_text(k);
        if (idx > 4'd9)
            return '0;
        return t[8*(9-int'(idx)) +: 8];
    endfunction

    function automatic logic [KW_LEN_W-1:0] kw_len(input logic [KW_IDX_W-1:0] k);
        logic [KW_LEN_W-1:0] l;
        unique case (k)
            3'd0:    l = 4'd6;
            3'd1:    l = 4'd10;
            3'd2:    l = 4'd10;
            3'd3:    l = 4'd4;
            3'd4:    l = 4'd5;
            default: l = 4'd0;
        endcase
        return l;
    endfunction

    function automatic logic [KIND_W-1:0] kw_kind(input logic [KW_IDX_W-1:0] k);
        logic [KIND_W-1:0] r;
        unique case (k)
            3'd0:    r = KIND_STRUCT;
            3'd1:    r = KIND_METASTRUCT;
            3'd2:    r = KIND_METAMETHOD;
            3'd3:    r = KIND_ENUM;
            3'd4:    r = KIND_CLASS;
            default: r = KIND_UNKNOWN;
        endcase
        return r;
    endfunction

    function automatic logic is_alpha(input logic [CHAR_W-1:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic logic is_digit(input logic [CHAR_W-1:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic logic is_blank(input logic [CHAR_W-1:0] b);
        return b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR;
    endfunction

    // {valid, kind}
    function automatic logic [KIND_W:0] punct_kind(input logic [CHAR_W-1:0] b);
        logic [KIND_W:0] r;
        unique case (b)
            "(":     r = {1'b1, KIND_LPAREN};
            ")":     r = {1'b1, KIND_RPAREN};
            "{":     r = {1'b1, KIND_LBRACE};
            "}":     r = {1'b1, KIND_RBRACE};
            ";":     r = {1'b1, KIND_SEMI};
            ":":     r = {1'b1, KIND_COLON};
            "*":     r = {1'b1, KIND_STAR};
            ",":     r = {1'b1, KIND_COMMA};
            "[":     r = {1'b1, KIND_LBRACKET};
            "]":     r = {1'b1, KIND_RBRACKET};
            default: r = {1'b0, KIND_UNKNOWN};
        endcase
        return r;
    endfunction

endpackage

### sv/srctok_lex.sv
// Lexer state and per-byte step: produces up to two token entries per accepted byte.
// Depends on srctok_pkg.
module srctok_lex #(
    parameter int POSITION_BITS = srctok_pkg::POSITION_BITS_DEF,
    parameter int LENGTH_BITS   = srctok_pkg::LENGTH_BITS_DEF,
    parameter int ENT_W         = 1 + 2 * LENGTH_BITS + POSITION_BITS + srctok_pkg::KIND_W
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  logic [srctok_pkg::CHAR_W-1:0]     char_byte,
    input  logic                              end_of_text,
    output srctok_pkg::push_t                 push,
    output logic [ENT_W-1:0]                  ent0,
    output logic [ENT_W-1:0]                  ent1
);

    typedef enum logic [2:0] {
        M_IDLE, M_WORD, M_NUMBER, M_SLASH, M_BLOCK, M_LINE, M_MM_SKIP, M_MM_EXTRA
    } mode_t;

    localparam int KW = srctok_pkg::KIND_W;
    localparam int KN = srctok_pkg::KW_COUNT;

    mode_t                     mode_reg,  mode_next;
    logic [POSITION_BITS-1:0]  pos_reg,   pos_next;
    logic [POSITION_BITS-1:0]  tstart_reg, tstart_next;
    logic [LENGTH_BITS-1:0]    run_reg,   run_next;
    logic [KN-1:0]             cand_reg,  cand_next;
    logic [LENGTH_BITS-1:0]    extra_reg, extra_next;
    logic                      star_reg,  star_next;

    logic                      a_v, b_v, c_v;
    logic [KW-1:0]             a_kind, b_kind, c_kind;
    logic [POSITION_BITS-1:0]  a_start, b_start, c_start;
    logic [LENGTH_BITS-1:0]    a_len, b_len, c_len;
    logic [LENGTH_BITS-1:0]    a_ext, c_ext;

    always_comb
    begin
        logic                    do_start;
        logic [KW:0]             pk;
        logic [KN-1:0]           cand_tmp;
        logic [LENGTH_BITS-1:0]  run_inc;
        logic                    found;
        logic [srctok_pkg::KW_IDX_W-1:0] hit;
        logic                    word_ch;

        mode_next   = mode_reg;
        pos_next    = pos_reg;
        tstart_next = tstart_reg;
        run_next    = run_reg;
        cand_next   = cand_reg;
        extra_next  = extra_reg;
        star_next   = star_reg;
        a_v = 1'b0; a_kind = srctok_pkg::KIND_IDENT; a_start = tstart_reg;
        a_len = run_reg; a_ext = '0;
        b_v = 1'b0; b_kind = srctok_pkg::KIND_UNKNOWN; b_start = pos_reg;
        b_len = LENGTH_BITS'(1);
        c_v = 1'b0; c_kind = srctok_pkg::KIND_IDENT; c_start = tstart_reg;
        c_len = run_reg; c_ext = '0;
        do_start = 1'b0;
        pk       = srctok_pkg::punct_kind(char_byte);
        word_ch  = srctok_pkg::is_alpha(char_byte) || srctok_pkg::is_digit(char_byte)
                   || char_byte == srctok_pkg::CH_UNDER;
        run_inc  = (run_reg == '1) ? run_reg : run_reg + 1'b1;
        cand_tmp = cand_reg;
        found    = 1'b0;
        hit      = '0;

        if (accept)
        begin
            unique case (mode_reg)
                M_WORD:
                begin
                    if (!word_ch)
                    begin
                        a_v      = 1'b1;
                        do_start = 1'b1;
                    end
                    else
                    begin
                        for (int k = 0; k < KN; k++)
                        begin
                            if (cand_reg[k] &&
                                (run_reg >= LENGTH_BITS'(srctok_pkg::kw_len(3'(k))) ||
                                 srctok_pkg::kw_char(3'(k), run_reg[3:0]) != char_byte))
                                cand_tmp[k] = 1'b0;
                        end
                        run_next = run_inc;
                        for (int k = 0; k < KN; k++)
                        begin
                            if (!found && cand_tmp[k] &&
                                run_inc == LENGTH_BITS'(srctok_pkg::kw_len(3'(k))))
                            begin
                                found = 1'b1;
                                hit   = 3'(k);
                            end
                        end
                        cand_next = cand_tmp;
                        if (found)
                        begin
                            cand_next = '0;
                            if (srctok_pkg::kw_kind(hit) == srctok_pkg::KIND_METAMETHOD)
                                mode_next = M_MM_SKIP;
                            else
                            begin
                                a_v       = 1'b1;
                                a_kind    = srctok_pkg::kw_kind(hit);
                                a_len     = LENGTH_BITS'(srctok_pkg::kw_len(hit));
                                mode_next = M_IDLE;
                            end
                        end
                    end
                end
                M_NUMBER:
                begin
                    if (srctok_pkg::is_digit(char_byte))
                        run_next = run_inc;
                    else
                    begin
                        a_v      = 1'b1;
                        a_kind   = srctok_pkg::KIND_NUMBER;
                        do_start = 1'b1;
                    end
                end
                M_SLASH:
                begin
                    if (char_byte == srctok_pkg::CH_STAR)
                    begin
                        mode_next = M_BLOCK;
                        star_next = 1'b0;
                    end
                    else if (char_byte == srctok_pkg::CH_SLASH)
                        mode_next = M_LINE;
                    else
                    begin
                        a_v      = 1'b1;
                        a_kind   = srctok_pkg::KIND_UNKNOWN;
                        a_len    = LENGTH_BITS'(1);
                        do_start = 1'b1;
                    end
                end
                M_BLOCK:
                begin
                    if (char_byte == srctok_pkg::CH_NUL)
                    begin
                        a_v = 1'b1; a_kind = srctok_pkg::KIND_UNKNOWN;
                        a_start = pos_reg; a_len = LENGTH_BITS'(1);
                        mode_next = M_IDLE;
                    end
                    else if (star_reg && char_byte == srctok_pkg::CH_SLASH)
                        mode_next = M_IDLE;
                    else
                        star_next = (char_byte == srctok_pkg::CH_STAR);
                end
                M_LINE:
                begin
                    if (char_byte == srctok_pkg::CH_NUL)
                    begin
                        a_v = 1'b1; a_kind = srctok_pkg::KIND_UNKNOWN;
                        a_start = pos_reg; a_len = LENGTH_BITS'(1);
                        mode_next = M_IDLE;
                    end
                    else if (char_byte == srctok_pkg::CH_LF)
                        mode_next = M_IDLE;
                end
                M_MM_SKIP:
                begin
                    extra_next = '0;
                    mode_next  = M_MM_EXTRA;
                end
                M_MM_EXTRA:
                begin
                    if (char_byte == srctok_pkg::CH_TAB || char_byte == srctok_pkg::CH_CR ||
                        char_byte == srctok_pkg::CH_LF)
                    begin
                        a_v = 1'b1; a_kind = srctok_pkg::KIND_METAMETHOD;
                        a_len = LENGTH_BITS'(srctok_pkg::MM_LEN); a_ext = extra_reg;
                        mode_next = M_IDLE;
                    end
                    else
                        extra_next = (extra_reg == '1) ? extra_reg : extra_reg + 1'b1;
                end
                default:
                    do_start = 1'b1;
            endcase

            if (do_start)
            begin
                mode_next = M_IDLE;
                if (srctok_pkg::is_blank(char_byte))
                    mode_next = M_IDLE;
                else if (char_byte == srctok_pkg::CH_SLASH)
                begin
                    mode_next   = M_SLASH;
                    tstart_next = pos_reg;
                end
                else if (pk[KW])
                begin
                    b_v    = 1'b1;
                    b_kind = pk[KW-1:0];
                end
                else if (srctok_pkg::is_alpha(char_byte))
                begin
                    mode_next   = M_WORD;
                    tstart_next = pos_reg;
                    run_next    = LENGTH_BITS'(1);
                    for (int k = 0; k < KN; k++)
                        cand_next[k] = (char_byte == srctok_pkg::kw_char(3'(k), 4'd0));
                end
                else if (srctok_pkg::is_digit(char_byte))
                begin
                    mode_next   = M_NUMBER;
                    tstart_next = pos_reg;
                    run_next    = LENGTH_BITS'(1);
                end
                else
                    b_v = 1'b1;
            end

            c_start = tstart_next;
            c_len   = run_next;
            if (end_of_text)
            begin
                unique case (mode_next)
                    M_WORD:
                        c_v = 1'b1;
                    M_NUMBER:
                    begin
                        c_v = 1'b1; c_kind = srctok_pkg::KIND_NUMBER;
                    end
                    M_SLASH:
                    begin
                        c_v = 1'b1; c_kind = srctok_pkg::KIND_UNKNOWN;
                        c_len = LENGTH_BITS'(1);
                    end
                    M_MM_SKIP:
                    begin
                        c_v = 1'b1; c_kind = srctok_pkg::KIND_METAMETHOD;
                        c_len = LENGTH_BITS'(srctok_pkg::MM_LEN);
                    end
                    M_MM_EXTRA:
                    begin
                        c_v = 1'b1; c_kind = srctok_pkg::KIND_METAMETHOD;
                        c_len = LENGTH_BITS'(srctok_pkg::MM_LEN); c_ext = extra_next;
                    end
                    default:
                        c_v = 1'b0;
                endcase
                mode_next   = M_IDLE;
                pos_next    = '0;
                tstart_next = '0;
                run_next    = '0;
                cand_next   = '0;
                extra_next  = '0;
                star_next   = 1'b0;
            end
            else
                pos_next = pos_reg + 1'b1;
        end
    end

    always_comb
    begin
        logic [ENT_W-2:0] ta, tb, tc;
        ta = {a_ext, a_len, a_start, a_kind};
        tb = {LENGTH_BITS'(0), b_len, b_start, b_kind};
        tc = {c_ext, c_len, c_start, c_kind};
        push.num = 2'(a_v) + 2'(b_v) + 2'(c_v);
        if (a_v)
        begin
            ent0 = {~(b_v | c_v), ta};
            ent1 = b_v ? {1'b1, tb} : {1'b1, tc};
        end
        else if (b_v)
        begin
            ent0 = {~c_v, tb};
            ent1 = {1'b1, tc};
        end
        else
        begin
            ent0 = {1'b1, tc};
            ent1 = {1'b1, tc};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= M_IDLE;
            pos_reg    <= '0;
            tstart_reg <= '0;
            run_reg    <= '0;
            cand_reg   <= '0;
            extra_reg  <= '0;
            star_reg   <= 1'b0;
        end
        else
        begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            tstart_reg <= tstart_next;
            run_reg    <= run_next;
            cand_reg   <= cand_next;
            extra_reg  <= extra_next;
            star_reg   <= star_next;
        end
    end

endmodule

### sv/srctok_queue.sv
// Token queue: takes up to two entries per cycle, delivers one per transaction.
// Depends on srctok_pkg.
module srctok_queue #(
    parameter int ENT_W = 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  srctok_pkg::push_t  push,
    input  logic [ENT_W-1:0]   ent0,
    input  logic [ENT_W-1:0]   ent1,
    output logic               room,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [ENT_W-1:0]   out_ent
);

    localparam int PW = srctok_pkg::TQ_PTR_W;
    localparam int CW = srctok_pkg::TQ_CNT_W;

    logic [ENT_W-1:0] mem [srctok_pkg::TQ_DEPTH];
    logic [PW-1:0]    wr_reg, wr_next;
    logic [PW-1:0]    rd_reg, rd_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             pop;

    assign room      = cnt_reg <= CW'(srctok_pkg::TQ_DEPTH - 2);
    assign out_valid = cnt_reg != '0;
    assign out_ent   = mem[rd_reg];
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_next  = wr_reg + PW'(push.num);
        rd_next  = rd_reg + PW'(pop);
        cnt_next = cnt_reg + CW'(push.num) - CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.num != 2'd0)
            mem[wr_reg] <= ent0;
        if (push.num == 2'd2)
            mem[wr_reg + 1'b1] <= ent1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

### sv/source_text_tokenizer.sv
// Top level of the source text tokenizer: lexer step plus a four-entry token queue.
// Tokens are written into the queue registers when their byte is accepted and leave from it.
// Throughput: one byte per cycle while the queue has room and each byte yields at most one
// token; a two-token byte costs two output transactions, set by the single-token output port.
// Reset (rst_n low, asynchronous) empties the queue and returns the lexer to idle at offset 0.
// Depends on srctok_pkg, srctok_lex, srctok_queue.
module source_text_tokenizer #(
    parameter int POSITION_BITS = srctok_pkg::POSITION_BITS_DEF,
    parameter int LENGTH_BITS   = srctok_pkg::LENGTH_BITS_DEF,
    parameter int OUT_W = ((srctok_pkg::KIND_W + POSITION_BITS + 2 * LENGTH_BITS + 7) / 8) * 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // char_byte
    input  logic             s_tlast,   // end_of_text
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,   // token_kind, start_offset, token_length, extra_length
    output logic             m_tlast    // last_of_run
);

    localparam int TOK_W = srctok_pkg::KIND_W + POSITION_BITS + 2 * LENGTH_BITS;
    localparam int ENT_W = TOK_W + 1;

    srctok_pkg::push_t  push;
    logic [ENT_W-1:0]   ent0, ent1, out_ent;
    logic               room;
    logic               accept;

    assign s_tready = room;
    assign accept   = s_tvalid && room;

    srctok_lex #(
        .POSITION_BITS(POSITION_BITS),
        .LENGTH_BITS  (LENGTH_BITS),
        .ENT_W        (ENT_W)
    ) u_lex (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .char_byte  (s_tdata),
        .end_of_text(s_tlast),
        .push       (push),
        .ent0       (ent0),
        .ent1       (ent1)
    );

    srctok_queue #(
        .ENT_W(ENT_W)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .ent0     (ent0),
        .ent1     (ent1),
        .room     (room),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_ent  (out_ent)
    );

    assign m_tdata = OUT_W'(out_ent[TOK_W-1:0]);
    assign m_tlast = out_ent[ENT_W-1];

endmodule

### tb/sv/token_checker.sv
`timescale 1ns / 100ps
// Token checker for the source text tokenizer: rebuilds the expected token stream from
// the accepted bytes and compares it field by field with the tokens leaving the block.
// Depends on srctok_pkg.
module token_checker #(
    parameter int POS_W = srctok_pkg::POSITION_BITS_DEF,
    parameter int LEN_W = srctok_pkg::LENGTH_BITS_DEF,
    parameter int OUT_W = ((srctok_pkg::KIND_W + POS_W + 2 * LEN_W + 7) / 8) * 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [7:0]       s_tdata,   // char_byte
    input  logic             s_tlast,   // end_of_text
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [OUT_W-1:0] m_tdata,   // token_kind, start_offset, token_length, extra_length
    input  logic             m_tlast,   // last_of_run
    output int               token_errors,
    output int               tokens_awaited
);
    import srctok_pkg::*;

    localparam int KW_STRUCT     = 0;
    localparam int KW_METASTRUCT = 1;
    localparam int KW_METAMETHOD = 2;
    localparam int KW_ENUM       = 3;
    localparam int KW_CLASS      = 4;
    localparam logic [LEN_W-1:0] METAMETHOD_TOKEN_LEN = LEN_W'(10);

    typedef enum logic [3:0] {
        SCAN_IDLE,
        SCAN_WORD,
        SCAN_NUMBER,
        SCAN_SLASH,
        SCAN_BLOCK,
        SCAN_LINE,
        SCAN_MM_SKIP,
        SCAN_MM_SIG
    } scan_state_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  start;
        logic [LEN_W-1:0]  length;
        logic [LEN_W-1:0]  extra;
        logic              last;
    } token_t;

    scan_state_t       scan_state;
    logic [POS_W-1:0]  offset;
    logic [POS_W-1:0]  tok_start;
    logic [LEN_W-1:0]  run_len;
    logic [LEN_W-1:0]  sig_len;
    logic [KW_COUNT-1:0] kw_live;
    logic              star_seen;

    token_t            expected_tokens [$];
    token_t            step_tok [2];
    int                step_n;
    token_t            seen;
    token_t            want;
    int                mismatch_total;

    function automatic string keyword_spelling(input int k);
        case (k)
            KW_STRUCT:     return "struct";
            KW_METASTRUCT: return "MetaStruct";
            KW_METAMETHOD: return "MetaMethod";
            KW_ENUM:       return "enum";
            default:       return "class";
        endcase
    endfunction

    function automatic logic [KIND_W-1:0] keyword_token(input int k);
        case (k)
            KW_STRUCT:     return KIND_STRUCT;
            KW_METASTRUCT: return KIND_METASTRUCT;
            KW_METAMETHOD: return KIND_METAMETHOD;
            KW_ENUM:       return KIND_ENUM;
            default:       return KIND_CLASS;
        endcase
    endfunction

    function automatic logic [KIND_W-1:0] punct_token(input logic [7:0] b);
        case (b)
            "(":     return KIND_LPAREN;
            ")":     return KIND_RPAREN;
            "{":     return KIND_LBRACE;
            "}":     return KIND_RBRACE;
            ";":     return KIND_SEMI;
            ":":     return KIND_COLON;
            "*":     return KIND_STAR;
            ",":     return KIND_COMMA;
            "[":     return KIND_LBRACKET;
            "]":     return KIND_RBRACKET;
            default: return KIND_UNKNOWN;
        endcase
    endfunction

    function automatic bit is_letter(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic bit is_numeral(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic bit is_space_byte(input logic [7:0] b);
        return b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR;
    endfunction

    function automatic logic [LEN_W-1:0] bump(input logic [LEN_W-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    function void add_token(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] start,
                            input logic [LEN_W-1:0] length, input logic [LEN_W-1:0] extra);
        if (step_n < 2)
        begin
            step_tok[step_n].kind   = kind;
            step_tok[step_n].start  = start;
            step_tok[step_n].length = length;
            step_tok[step_n].extra  = extra;
            step_tok[step_n].last   = 1'b0;
            step_n++;
        end
    endfunction

    function void clear_scan();
        scan_state = SCAN_IDLE;
        offset     = '0;
        tok_start  = '0;
        run_len    = '0;
        sig_len    = '0;
        kw_live    = '0;
        star_seen  = 1'b0;
    endfunction

    function void open_token(input logic [7:0] b, input logic [POS_W-1:0] pos);
        scan_state = SCAN_IDLE;
        if (is_space_byte(b))
            return;
        if (b == CH_SLASH)
        begin
            scan_state = SCAN_SLASH;
            tok_start  = pos;
        end
        else if (punct_token(b) != KIND_UNKNOWN)
            add_token(punct_token(b), pos, 1, 0);
        else if (is_letter(b))
        begin
            scan_state = SCAN_WORD;
            tok_start  = pos;
            run_len    = 1;
            kw_live    = '0;
            case (b)
                "s":
                    kw_live[KW_STRUCT] = 1'b1;
                "M":
                begin
                    kw_live[KW_METASTRUCT] = 1'b1;
                    kw_live[KW_METAMETHOD] = 1'b1;
                end
                "e":
                    kw_live[KW_ENUM] = 1'b1;
                "c":
                    kw_live[KW_CLASS] = 1'b1;
                default:
                    kw_live = '0;
            endcase
        end
        else if (is_numeral(b))
        begin
            scan_state = SCAN_NUMBER;
            tok_start  = pos;
            run_len    = 1;
        end
        else
            add_token(KIND_UNKNOWN, pos, 1, 0);
    endfunction

    function void word_byte(input logic [7:0] b, input logic [POS_W-1:0] pos);
        int    k;
        string word;
        if (!(is_letter(b) || is_numeral(b) || b == CH_UNDER))
        begin
            add_token(KIND_IDENT, tok_start, run_len, 0);
            open_token(b, pos);
            return;
        end
        for (k = 0; k < KW_COUNT; k++)
        begin
            if (kw_live[k])
            begin
                word = keyword_spelling(k);
                if (int'(run_len) >= word.len() || word[int'(run_len)] != b)
                    kw_live[k] = 1'b0;
            end
        end
        run_len = bump(run_len);
        for (k = 0; k < KW_COUNT; k++)
        begin
            word = keyword_spelling(k);
            if (kw_live[k] && int'(run_len) == word.len())
            begin
                kw_live = '0;
                if (k == KW_METAMETHOD)
                    scan_state = SCAN_MM_SKIP;
                else
                begin
                    add_token(keyword_token(k), tok_start, LEN_W'(word.len()), 0);
                    scan_state = SCAN_IDLE;
                end
                return;
            end
        end
    endfunction

    function void predict_byte(input logic [7:0] b, input logic eot);
        int i;
        step_n = 0;
        case (scan_state)
            SCAN_WORD:
                word_byte(b, offset);
            SCAN_NUMBER:
                if (is_numeral(b))
                    run_len = bump(run_len);
                else
                begin
                    add_token(KIND_NUMBER, tok_start, run_len, 0);
                    open_token(b, offset);
                end
            SCAN_SLASH:
                if (b == CH_STAR)
                begin
                    scan_state = SCAN_BLOCK;
                    star_seen  = 1'b0;
                end
                else if (b == CH_SLASH)
                    scan_state = SCAN_LINE;
                else
                begin
                    add_token(KIND_UNKNOWN, tok_start, 1, 0);
                    open_token(b, offset);
                end
            SCAN_BLOCK:
                if (b == CH_NUL)
                begin
                    add_token(KIND_UNKNOWN, offset, 1, 0);
                    scan_state = SCAN_IDLE;
                end
                else if (star_seen && b == CH_SLASH)
                    scan_state = SCAN_IDLE;
                else
                    star_seen = (b == CH_STAR);
            SCAN_LINE:
                if (b == CH_NUL)
                begin
                    add_token(KIND_UNKNOWN, offset, 1, 0);
                    scan_state = SCAN_IDLE;
                end
                else if (b == CH_LF)
                    scan_state = SCAN_IDLE;
            SCAN_MM_SKIP:
            begin
                sig_len    = '0;
                scan_state = SCAN_MM_SIG;
            end
            SCAN_MM_SIG:
                if (b == CH_TAB || b == CH_CR || b == CH_LF)
                begin
                    add_token(KIND_METAMETHOD, tok_start, METAMETHOD_TOKEN_LEN, sig_len);
                    scan_state = SCAN_IDLE;
                end
                else
                    sig_len = bump(sig_len);
            default:
                open_token(b, offset);
        endcase

        if (eot)
        begin
            case (scan_state)
                SCAN_WORD:    add_token(KIND_IDENT, tok_start, run_len, 0);
                SCAN_NUMBER:  add_token(KIND_NUMBER, tok_start, run_len, 0);
                SCAN_SLASH:   add_token(KIND_UNKNOWN, tok_start, 1, 0);
                SCAN_MM_SKIP: add_token(KIND_METAMETHOD, tok_start, METAMETHOD_TOKEN_LEN, 0);
                SCAN_MM_SIG:  add_token(KIND_METAMETHOD, tok_start, METAMETHOD_TOKEN_LEN,
                                        sig_len);
                default:      ;
            endcase
            clear_scan();
        end
        else
            offset = offset + 1'b1;

        if (step_n > 0)
            step_tok[step_n-1].last = 1'b1;
        for (i = 0; i < step_n; i++)
            expected_tokens.push_back(step_tok[i]);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_scan();
            expected_tokens.delete();
            mismatch_total = 0;
            token_errors   <= 0;
            tokens_awaited <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                predict_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
            begin
                seen.kind   = m_tdata[KIND_W-1:0];
                seen.start  = m_tdata[KIND_W +: POS_W];
                seen.length = m_tdata[KIND_W + POS_W +: LEN_W];
                seen.extra  = m_tdata[KIND_W + POS_W + LEN_W +: LEN_W];
                seen.last   = m_tlast;
                if (expected_tokens.size() == 0)
                begin
                    mismatch_total++;
                    if (mismatch_total <= 10)
                        $display({"unexpected token: kind %0d start %0d length %0d",
                                  " extra %0d last %0b"},
                                 seen.kind, seen.start, seen.length, seen.extra, seen.last);
                end
                else
                begin
                    want = expected_tokens.pop_front();
                    if (seen != want)
                    begin
                        mismatch_total++;
                        if (mismatch_total <= 10)
                            $display({"token mismatch: expected kind %0d start %0d length %0d",
                                      " extra %0d last %0b, got kind %0d start %0d length %0d",
                                      " extra %0d last %0b"},
                                     want.kind, want.start, want.length, want.extra, want.last,
                                     seen.kind, seen.start, seen.length, seen.extra, seen.last);
                    end
                end
            end
            token_errors   <= mismatch_total;
            tokens_awaited <= expected_tokens.size();
        end
    end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// Testbench top for the source text tokenizer: clock, reset, byte texts with random gaps,
// output back-pressure and the verdict. Depends on srctok_pkg, source_text_tokenizer and
// token_checker.
module testbench;
    import srctok_pkg::*;

    localparam int POS_W        = POSITION_BITS_DEF;
    localparam int LEN_W        = LENGTH_BITS_DEF;
    localparam int OUT_W        = ((KIND_W + POS_W + 2 * LEN_W + 7) / 8) * 8;
    localparam int LONG_RUN     = 40;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_BYTES = 250;
    localparam int QUIET_BYTES  = 60;
    localparam int SETTLE       = 20;

    logic             clk      = 1'b0;
    logic             rst_n    = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [7:0]       s_tdata  = '0;
    logic             s_tlast  = 1'b0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic             m_tlast;

    int               token_errors;
    int               tokens_awaited;
    bit               gaps_on      = 1'b0;
    bit               hold_request = 1'b0;
    logic [7:0]       text_q [$];

    always #4 clk = ~clk;

    source_text_tokenizer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    token_checker #(
        .POS_W (POS_W),
        .LEN_W (LEN_W),
        .OUT_W (OUT_W)
    ) token_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .token_errors   (token_errors),
        .tokens_awaited (tokens_awaited)
    );

    function automatic logic [7:0] pick(input string choices);
        return choices[$urandom_range(0, choices.len() - 1)];
    endfunction

    task automatic add_str(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic eot);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eot;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
    endtask

    // one transaction per byte; the end marker rides on the final byte
    task automatic send_text();
        int i;
        for (i = 0; i < text_q.size(); i++)
            send_byte(text_q[i], i == text_q.size() - 1);
        text_q.delete();
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (tokens_awaited != 0);
    endtask

    initial
    begin
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
                m_tready <= 1'b1;
            end
            else if (gaps_on && $urandom_range(0, 7) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin
        #8_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        int         i;
        int         cut;
        int         random_sent;
        logic [7:0] b;

        random_sent = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        gaps_on = 1'b1;

        add_str("struct enum class MetaStruct structure Metax x_9 Z 0123 _a");
        send_text();
        add_str("ab(12;/x/*/ */// c\n/**/q");
        send_text();
        text_q.push_back(8'hFF);
        text_q.push_back(8'h80);
        text_q.push_back(8'h7F);
        text_q.push_back(CH_NUL);
        add_str("/*a");
        text_q.push_back(CH_NUL);
        add_str("//b");
        text_q.push_back(CH_NUL);
        add_str("MetaMethod(");
        text_q.push_back(CH_NUL);
        add_str("z\r");
        send_text();
        add_str("MetaMethod");
        send_text();
        add_str("MetaMethod(a");
        send_text();
        add_str("Met");
        send_text();
        add_str("/* x");
        send_text();
        add_str("/");
        send_text();
        add_str("42");
        send_text();
        drain();

        // stall the output while the input keeps offering punctuation
        hold_request = 1'b1;
        repeat (3) add_str("(){};:*,[]");
        send_text();
        drain();

        // long word and signature runs back to back
        gaps_on = 1'b0;
        for (i = 0; i < LONG_RUN; i++)
            text_q.push_back("q");
        add_str(";");
        send_text();
        add_str("MetaMethod(");
        for (i = 0; i < LONG_RUN; i++)
            text_q.push_back("x");
        add_str("\n");
        send_text();
        drain();
        gaps_on = 1'b1;

        while (random_sent < RANDOM_BYTES)
        begin
            if (random_sent >= RANDOM_BYTES - QUIET_BYTES)
                gaps_on = 1'b0;
            repeat ($urandom_range(2, 10))
            begin
                case ($urandom_range(0, 12))
                    0:
                        case ($urandom_range(0, 4))
                            0:       add_str("struct");
                            1:       add_str("enum");
                            2:       add_str("class");
                            3:       add_str("MetaStruct");
                            default: add_str("Meta");
                        endcase
                    1:
                    begin
                        add_str("MetaMethod");
                        text_q.push_back(8'($urandom_range(0, 255)));
                        repeat ($urandom_range(0, 10))
                        begin
                            b = 8'($urandom_range(0, 255));
                            if (b == CH_TAB || b == CH_CR || b == CH_LF)
                                b = "x";
                            text_q.push_back(b);
                        end
                        text_q.push_back(pick("\t\r\n"));
                    end
                    2:
                    begin
                        text_q.push_back(pick("abcxyzMSEAmsec"));
                        repeat ($urandom_range(0, 6))
                            text_q.push_back(pick("aetsuMcl_09Z"));
                    end
                    3:
                        repeat ($urandom_range(1, 5))
                            text_q.push_back(pick("0123456789"));
                    4, 5:
                        text_q.push_back(pick("(){};:*,[]"));
                    6, 7:
                        repeat ($urandom_range(1, 3))
                            text_q.push_back(pick(" \t\r\n"));
                    8:
                    begin
                        add_str("//");
                        repeat ($urandom_range(0, 8))
                            text_q.push_back(pick("ab */x;"));
                        if ($urandom_range(0, 5) == 0)
                            text_q.push_back(CH_NUL);
                        else
                            add_str("\n");
                    end
                    9:
                    begin
                        add_str("/*");
                        repeat ($urandom_range(0, 8))
                            text_q.push_back(pick("ab */x\n"));
                        if ($urandom_range(0, 5) == 0)
                            text_q.push_back(CH_NUL);
                        else
                            add_str("*/");
                    end
                    10:
                    begin
                        add_str("/");
                        text_q.push_back(pick("a(1 ;"));
                    end
                    11:
                        text_q.push_back(8'($urandom_range(0, 255)));
                    default:
                    begin
                        add_str("_");
                        text_q.push_back(pick("abMs"));
                    end
                endcase
            end
            // cut some texts short so the end marker lands mid-token
            if ($urandom_range(0, 4) == 0)
            begin
                cut = $urandom_range(1, text_q.size());
                while (text_q.size() > cut)
                    text_q.delete(text_q.size() - 1);
            end
            random_sent += text_q.size();
            send_text();
            if ($urandom_range(0, 9) == 0)
                drain();
        end

        drain();
        repeat (SETTLE) @(posedge clk);
        if (token_errors == 0 && tokens_awaited == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
